// ===== rtl/wedge_count_edge_sampler_top_macros.svh =====
// Assertion helpers shared by the RTL. They expect clk and rst_n in scope.
`ifndef WEDGE_COUNT_EDGE_SAMPLER_TOP_MACROS_SVH
`define WEDGE_COUNT_EDGE_SAMPLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wcs_pkg.sv =====
package wcs_pkg;

  localparam int VERTEX_COUNT_DEF = 4096;

  localparam int ID_W     = 12;
  localparam int COIN_W   = 16;
  localparam int PROB_W   = 17;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W    = 40;
  localparam int EST_W    = 64;
  localparam int CNT_W    = 32;
  localparam int FRAC_W   = 16;
  // The vertex sum is multiplied in two halves of this width.
  localparam int HALF_W   = 20;
  localparam int PROD_W   = 57;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PROB_FRESH      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PROB_TOUCHING   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FRESH    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TOUCHING = CFG_IDX_W'(3);

  localparam logic [PROB_W-1:0]   PROB_ONE   = PROB_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

  typedef struct packed {
    logic             seen;
    logic [SUM_W-1:0] sum;
  } vtx_entry_t;

  localparam int ENT_W = $bits(vtx_entry_t);

endpackage

// ===== rtl/wcs_if.sv =====
interface wcs_in_if import wcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   vertex_a;
  logic [ID_W-1:0]   vertex_b;
  logic [COIN_W-1:0] coin;

  modport source(output valid, vertex_a, vertex_b, coin, input ready);
  modport sink(input valid, vertex_a, vertex_b, coin, output ready);
endinterface

interface wcs_out_if import wcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kept;
  logic [EST_W-1:0] estimate;
  logic [CNT_W-1:0] kept_count;

  modport source(output valid, kept, estimate, kept_count, input ready);
  modport sink(input valid, kept, estimate, kept_count, output ready);
endinterface

// ===== rtl/wcs_ram.sv =====
module wcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== rtl/wcs_mul.sv =====
module wcs_mul import wcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WEIGHT_W-1:0] w,
  input  logic [SUM_W-1:0]    s,
  output logic                done,
  output logic [PROD_W-1:0]   prod
);

  localparam int PART_W = WEIGHT_W + HALF_W;

  typedef enum logic [1:0] {M_IDLE, M_HI, M_LO, M_SUM} mstate_t;

  mstate_t             state_r, state_nxt;
  logic [WEIGHT_W-1:0] w_r;
  logic [SUM_W-1:0]    s_r;
  logic [HALF_W-1:0]   mul_b;
  logic [PART_W-1:0]   mul_p;
  logic [PART_W-1:0]   p_hi_r;
  logic [PART_W-1:0]   p_lo_r;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                done_r;

  // One 32 x 20 multiplier serves the upper and then the lower half of the sum.
  assign mul_b = (state_r == M_HI) ? s_r[SUM_W-1:HALF_W] : s_r[HALF_W-1:0];
  assign mul_p = PART_W'(w_r) * PART_W'(mul_b);

  assign prod_nxt = PROD_W'({p_hi_r, {(HALF_W-FRAC_W){1'b0}}}) + PROD_W'(p_lo_r >> FRAC_W);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          state_nxt = M_HI;
        end
      end
      M_HI:    state_nxt = M_LO;
      M_LO:    state_nxt = M_SUM;
      M_SUM:   state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == M_SUM);
    end
    if (state_r == M_IDLE && start) begin
      w_r <= w;
      s_r <= s;
    end
    if (state_r == M_HI) begin
      p_hi_r <= mul_p;
    end
    if (state_r == M_LO) begin
      p_lo_r <= mul_p;
    end
    if (state_r == M_SUM) begin
      prod_r <= prod_nxt;
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== rtl/wedge_count_edge_sampler_top.sv =====
// Channel  | Dir | Payload                          | Handshake
// in_ch    | in  | vertex_a, vertex_b, coin         | valid / ready
// out_ch   | out | kept, estimate, kept_count       | valid / ready
// cfg      | in  | cfg_index, cfg_wdata             | cfg_we, no wait
//
// One request is worked on at a time. A self loop or out-of-range edge and a dropped
// edge go straight to the output; a kept edge visits each end in turn, and an already seen
// end also waits for a product from the single shared multiplier.
// After reset the vertex memory is cleared one entry a cycle, all VERTEX_COUNT entries,
// while in_ch.ready stays low; configuration writes are taken throughout.
// A result waits in the output register while the next request is accepted.
`include "wedge_count_edge_sampler_top_macros.svh"

module wedge_count_edge_sampler_top import wcs_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wcs_in_if.sink                in_ch,
  wcs_out_if.source             out_ch
);

  localparam int AW    = $clog2(VERTEX_COUNT);
  localparam int CMP_W = (AW > ID_W) ? AW + 1 : ID_W + 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(VERTEX_COUNT - 1);
  localparam logic [CMP_W-1:0] ID_LIMIT  = CMP_W'(VERTEX_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_VISIT, S_MWAIT, S_OUT
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_addr_r;
  logic [ID_W-1:0]     lo_id_r, hi_id_r;
  logic [COIN_W-1:0]   coin_r;
  vtx_entry_t          ent_a_r, ent_b_r;
  logic [WEIGHT_W-1:0] w_r;
  logic                end_r;
  logic                kept_r;
  logic [EST_W-1:0]    estimate_r;
  logic [CNT_W-1:0]    kept_cnt_r;
  logic [PROB_W-1:0]   prob_fresh_r, prob_touching_r;
  logic [WEIGHT_W-1:0] weight_fresh_r, weight_touching_r;
  logic                out_valid_r;
  logic                out_kept_r;
  logic [EST_W-1:0]    out_est_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic                in_take;
  logic                edge_ok;
  logic [ENT_W-1:0]    rd0, rd1;
  vtx_entry_t          rd_a, rd_b;
  logic                fresh;
  logic [PROB_W-1:0]   prob;
  logic                keep;
  vtx_entry_t          cur_ent;
  logic [AW-1:0]       cur_addr;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_sat;
  logic [EST_W:0]      est_add;
  logic [EST_W-1:0]    est_sat;
  logic                mul_start;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  vtx_entry_t          wr_data;
  logic                out_load;

  assign in_take = in_ch.valid && (state_r == S_IDLE);
  assign edge_ok = (lo_id_r != hi_id_r) && (CMP_W'(hi_id_r) < ID_LIMIT);

  assign rd_a  = vtx_entry_t'(rd0);
  assign rd_b  = vtx_entry_t'(rd1);
  assign fresh = !rd_a.seen && !rd_b.seen;
  assign prob  = fresh ? prob_fresh_r : prob_touching_r;
  assign keep  = PROB_W'(coin_r) <= prob;

  assign cur_ent  = end_r ? ent_b_r : ent_a_r;
  assign cur_addr = end_r ? AW'(hi_id_r) : AW'(lo_id_r);

  assign sum_add = (SUM_W+1)'(cur_ent.sum) + (SUM_W+1)'(w_r);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign est_add = (EST_W+1)'(estimate_r) + (EST_W+1)'(mul_prod);
  assign est_sat = est_add[EST_W] ? {EST_W{1'b1}} : est_add[EST_W-1:0];

  assign mul_start = (state_r == S_VISIT) && cur_ent.seen;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = cur_addr;
    wr_data.seen = 1'b1;
    wr_data.sum  = SUM_W'(w_r);
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      S_VISIT: wr_en = !cur_ent.seen;
      S_MWAIT: begin
        wr_en       = mul_done;
        wr_data.sum = sum_sat;
      end
      default: wr_en = 1'b0;
    endcase
  end

  wcs_ram #(
    .WIDTH(ENT_W),
    .DEPTH(VERTEX_COUNT)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr0(AW'(lo_id_r)),
    .raddr1(AW'(hi_id_r)),
    .rdata0(rd0),
    .rdata1(rd1)
  );

  wcs_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .w    (w_r),
    .s    (cur_ent.sum),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_CLEAR;
      clr_addr_r        <= '0;
      end_r             <= 1'b0;
      kept_r            <= 1'b0;
      estimate_r        <= '0;
      kept_cnt_r        <= '0;
      prob_fresh_r      <= PROB_ONE;
      prob_touching_r   <= PROB_ONE;
      weight_fresh_r    <= WEIGHT_ONE;
      weight_touching_r <= WEIGHT_ONE;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROB_FRESH:      prob_fresh_r      <= PROB_W'(cfg_wdata);
          CFG_PROB_TOUCHING:   prob_touching_r   <= PROB_W'(cfg_wdata);
          CFG_WEIGHT_FRESH:    weight_fresh_r    <= WEIGHT_W'(cfg_wdata);
          CFG_WEIGHT_TOUCHING: weight_touching_r <= WEIGHT_W'(cfg_wdata);
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          kept_r  <= 1'b0;
          state_r <= edge_ok ? S_DECIDE : S_OUT;
        end
        S_DECIDE: begin
          kept_r <= keep;
          end_r  <= 1'b0;
          if (keep) begin
            if (kept_cnt_r != {CNT_W{1'b1}}) begin
              kept_cnt_r <= kept_cnt_r + CNT_W'(1);
            end
            state_r <= S_VISIT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_VISIT: begin
          if (cur_ent.seen) begin
            state_r <= S_MWAIT;
          end else if (end_r) begin
            state_r <= S_OUT;
          end else begin
            end_r <= 1'b1;
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            estimate_r <= est_sat;
            end_r      <= 1'b1;
            state_r    <= end_r ? S_OUT : S_VISIT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    // Payload registers.
    if (in_take) begin
      lo_id_r <= (in_ch.vertex_a < in_ch.vertex_b) ? in_ch.vertex_a : in_ch.vertex_b;
      hi_id_r <= (in_ch.vertex_a < in_ch.vertex_b) ? in_ch.vertex_b : in_ch.vertex_a;
      coin_r  <= in_ch.coin;
    end
    if (state_r == S_DECIDE) begin
      ent_a_r <= rd_a;
      ent_b_r <= rd_b;
      w_r     <= fresh ? weight_fresh_r : weight_touching_r;
    end
    if (out_load) begin
      out_kept_r <= kept_r;
      out_est_r  <= estimate_r;
      out_cnt_r  <= kept_cnt_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kept       = out_kept_r;
  assign out_ch.estimate   = out_est_r;
  assign out_ch.kept_count = out_cnt_r;

  `WCS_ASSERT_NEXT(a_est_monotonic, 1'b1, estimate_r >= $past(estimate_r), "estimate decreased")
  `WCS_ASSERT_NEXT(a_cnt_monotonic, 1'b1, kept_cnt_r >= $past(kept_cnt_r), "kept count decreased")
  `WCS_ASSERT_NOW(a_no_write_idle, state_r == S_IDLE, !wr_en, "vertex write while idle")
  `WCS_ASSERT_NOW(a_mul_done_wait, mul_done, state_r == S_MWAIT, "product with no waiting end")

endmodule

// ===== tb/wedge_count_edge_sampler_top_test.sv =====
`timescale 1ns / 1ps

module wedge_count_edge_sampler_top_test;
  import wcs_pkg::*;

  localparam int VTX = VERTEX_COUNT_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX      = '1;
  localparam int PRINT_CAP   = 40;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic             kept;
    logic [EST_W-1:0] estimate;
    logic [CNT_W-1:0] kept_count;
  } wedge_result_t;

  typedef enum bit {STEP_EDGE, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    logic [ID_W-1:0]       va;
    logic [ID_W-1:0]       vb;
    logic [COIN_W-1:0]     coin;
    bit                    typed;
    wedge_result_t         want;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wcs_in_if  in_ch();
  wcs_out_if out_ch();

  wedge_count_edge_sampler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copy of the sampler: registers, vertex table and running totals.
  logic [PROB_W-1:0]   p_fresh;
  logic [PROB_W-1:0]   p_touch;
  logic [WEIGHT_W-1:0] w_fresh;
  logic [WEIGHT_W-1:0] w_touch;
  bit                  seen_tbl [VTX];
  logic [SUM_W-1:0]    sum_tbl [VTX];
  logic [EST_W-1:0]    est_acc;
  logic [CNT_W-1:0]    kept_tally;

  wedge_result_t pending_results[$];
  wedge_result_t oldest_result;
  step_t         script[$];

  int error_count     = 0;
  int edges_sent      = 0;
  int typed_rows      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout: requests still outstanding at %0t", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [EST_W-1:0] got,
                               input logic [EST_W-1:0] exp_val);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("MISMATCH at %0t: %s, got %0h, expected %0h", $time, what, got, exp_val);
  endtask

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PROB_FRESH:      p_fresh = data[PROB_W-1:0];
      CFG_PROB_TOUCHING:   p_touch = data[PROB_W-1:0];
      CFG_WEIGHT_FRESH:    w_fresh = data[WEIGHT_W-1:0];
      CFG_WEIGHT_TOUCHING: w_touch = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  // A seen end adds w times its sum to the estimate before its own sum grows by w.
  function automatic void credit_vertex(input logic [ID_W-1:0] v,
                                        input logic [WEIGHT_W-1:0] w);
    logic [WEIGHT_W+SUM_W-1:0] product;
    logic [EST_W:0]            total;
    logic [SUM_W:0]            grown;
    if (seen_tbl[v]) begin
      product = {{SUM_W{1'b0}}, w} * {{WEIGHT_W{1'b0}}, sum_tbl[v]};
      total = {1'b0, est_acc} + {1'b0, EST_W'(product >> FRAC_W)};
      est_acc = total[EST_W] ? '1 : total[EST_W-1:0];
      grown = {1'b0, sum_tbl[v]} + {{(SUM_W+1-WEIGHT_W){1'b0}}, w};
      sum_tbl[v] = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
    end else begin
      seen_tbl[v] = 1'b1;
      sum_tbl[v] = SUM_W'(w);
    end
  endfunction

  function automatic wedge_result_t estimate_after_edge(input logic [ID_W-1:0] va,
                                                        input logic [ID_W-1:0] vb,
                                                        input logic [COIN_W-1:0] coin);
    logic [ID_W-1:0]     lo;
    logic [ID_W-1:0]     hi;
    logic                fresh;
    logic [PROB_W-1:0]   prob;
    logic [WEIGHT_W-1:0] w;
    wedge_result_t       r;
    lo = (va > vb) ? vb : va;
    hi = (va > vb) ? va : vb;
    r.kept = 1'b0;
    if (lo != hi && int'(hi) < VTX) begin
      fresh = !seen_tbl[lo] && !seen_tbl[hi];
      prob = fresh ? p_fresh : p_touch;
      w = fresh ? w_fresh : w_touch;
      if ({1'b0, coin} <= prob) begin
        r.kept = 1'b1;
        if (kept_tally != '1) kept_tally = kept_tally + CNT_W'(1);
        credit_vertex(lo, w);
        credit_vertex(hi, w);
      end
    end
    r.estimate = est_acc;
    r.kept_count = kept_tally;
    return r;
  endfunction

  function automatic step_t pair_step(input logic [ID_W-1:0] va, input logic [ID_W-1:0] vb,
                                      input logic [COIN_W-1:0] coin, input bit typed = 1'b0,
                                      input logic kept = 1'b0, input logic [EST_W-1:0] est = '0,
                                      input logic [CNT_W-1:0] cnt = '0);
    step_t s;
    s.kind = STEP_EDGE;
    s.index = '0;
    s.wdata = '0;
    s.va = va;
    s.vb = vb;
    s.coin = coin;
    s.typed = typed;
    s.want = '{kept: kept, estimate: est, kept_count: cnt};
    return s;
  endfunction

  function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = pair_step('0, '0, '0);
    s.kind = STEP_REG;
    s.index = idx;
    s.wdata = data;
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_prob();
    case ($urandom_range(5))
      0: return CFG_DATA_W'(PROB_ONE);
      1: return '0;
      2: return CFG_DATA_W'($urandom_range(0, 65536));
      3: return CFG_DATA_W'($urandom_range(65537, 131071));
      default: return CFG_DATA_W'($urandom_range(32768, 65536));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    case ($urandom_range(3))
      0: return CFG_DATA_W'(WEIGHT_ONE);
      1: return CFG_DATA_W'($urandom_range(0, 65535));
      default: return CFG_DATA_W'($urandom_range(65536, 65536 * 8));
    endcase
  endfunction

  // Called at a falling edge while the sampler is idle; drops cfg_we again before it returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_edge(input logic [ID_W-1:0] va, input logic [ID_W-1:0] vb,
                           input logic [COIN_W-1:0] coin, input bit typed,
                           input wedge_result_t want);
    wedge_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.vertex_a <= va;
    in_ch.vertex_b <= vb;
    in_ch.coin <= coin;
    do @(posedge clk); while (!in_ch.ready);
    // The shadow state must advance on every request, typed rows included.
    predicted = estimate_after_edge(va, vb, coin);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    edges_sent++;
    if (typed) typed_rows++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic run_random_phase(input int n_edges, input int idle_pct, input int stall_pct,
                                  input int pool_size, input bit heavy);
    logic [ID_W-1:0]   base;
    logic [ID_W-1:0]   va;
    logic [ID_W-1:0]   vb;
    logic [COIN_W-1:0] coin;
    int                roll;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    settings_used++;
    if (heavy) begin
      write_reg(CFG_PROB_FRESH, CFG_DATA_W'(PROB_ONE));
      write_reg(CFG_PROB_TOUCHING, CFG_DATA_W'(PROB_ONE));
      write_reg(CFG_WEIGHT_FRESH, WEIGHT_MAX);
      write_reg(CFG_WEIGHT_TOUCHING, WEIGHT_MAX);
    end else begin
      write_reg(CFG_PROB_FRESH, pick_prob());
      write_reg(CFG_PROB_TOUCHING, pick_prob());
      write_reg(CFG_WEIGHT_FRESH, pick_weight());
      write_reg(CFG_WEIGHT_TOUCHING, pick_weight());
      if ($urandom_range(1) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom());
    end
    base = ID_W'($urandom());
    va = base;
    vb = base + ID_W'(1);
    for (int i = 0; i < n_edges; i++) begin
      roll = $urandom_range(99);
      // Most edges stay inside a small vertex pool so that ends are seen again and again.
      if (heavy || roll < 70) begin
        va = base + ID_W'($urandom_range(pool_size - 1));
        vb = base + ID_W'($urandom_range(pool_size - 1));
        while (heavy && vb == va) vb = base + ID_W'($urandom_range(pool_size - 1));
      end else if (roll < 85) begin
        va = ID_W'($urandom());
        vb = ID_W'($urandom());
      end else if (roll < 92) begin
        va = ID_W'($urandom());
        vb = va;
      end else begin
        {va, vb} = {vb, va};
      end
      case ($urandom_range(9))
        0: coin = '0;
        1: coin = '1;
        default: coin = COIN_W'($urandom());
      endcase
      push_edge(va, vb, coin, 1'b0, '0);
    end
    wait_drained();
  endtask

  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request outstanding", out_ch.estimate, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (out_ch.kept !== oldest_result.kept)
          flag_mismatch("kept", EST_W'(out_ch.kept), EST_W'(oldest_result.kept));
        if (out_ch.estimate !== oldest_result.estimate)
          flag_mismatch("estimate", out_ch.estimate, oldest_result.estimate);
        if (out_ch.kept_count !== oldest_result.kept_count)
          flag_mismatch("kept_count", EST_W'(out_ch.kept_count),
                        EST_W'(oldest_result.kept_count));
      end
    end
  end

  initial begin
    bit drained;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    in_ch.coin = '0;
    p_fresh = PROB_ONE;
    p_touch = PROB_ONE;
    w_fresh = WEIGHT_ONE;
    w_touch = WEIGHT_ONE;
    for (int v = 0; v < VTX; v++) begin
      seen_tbl[v] = 1'b0;
      sum_tbl[v] = '0;
    end
    est_acc = '0;
    kept_tally = '0;

    // Typed rows start from the reset settings: probabilities and weights all one.
    script = '{
      pair_step(12'd5, 12'd5, 16'd0, 1'b1, 1'b0, 64'd0, 32'd0),
      pair_step(12'd0, 12'd4095, 16'hFFFF, 1'b1, 1'b1, 64'd0, 32'd1),
      pair_step(12'd4095, 12'd0, 16'd0, 1'b1, 1'b1, 64'd131072, 32'd2),
      reg_step(CFG_PROB_FRESH, 32'd0),
      pair_step(12'd10, 12'd20, 16'd1, 1'b1, 1'b0, 64'd131072, 32'd2),
      pair_step(12'd20, 12'd10, 16'd0, 1'b1, 1'b1, 64'd131072, 32'd3),
      reg_step(CFG_PROB_TOUCHING, 32'hFFFF_FFFF),
      pair_step(12'd30, 12'd20, 16'hFFFF, 1'b1, 1'b1, 64'd196608, 32'd4),
      reg_step(CFG_WEIGHT_TOUCHING, 32'hFFFF_FFFF),
      reg_step(CFG_WEIGHT_FRESH, 32'd0),
      reg_step(CFG_PROB_FRESH, CFG_DATA_W'(PROB_ONE)),
      pair_step(12'd100, 12'd200, 16'hFFFF, 1'b1, 1'b1, 64'd196608, 32'd5),
      pair_step(12'd300, 12'd100, 16'd12345, 1'b1, 1'b1, 64'd196608, 32'd6),
      pair_step(12'd100, 12'd300, 16'd0),
      pair_step(12'd300, 12'd100, 16'hFFFF),
      reg_step(CFG_SPARE_FIRST, 32'hFFFF_FFFF),
      reg_step(CFG_SPARE_LAST, 32'd0),
      reg_step(CFG_PROB_TOUCHING, 32'd65535),
      pair_step(12'd0, 12'd1, 16'hFFFF),
      reg_step(CFG_PROB_TOUCHING, 32'd0),
      reg_step(CFG_WEIGHT_TOUCHING, CFG_DATA_W'(WEIGHT_ONE)),
      pair_step(12'd4095, 12'd1, 16'd1),
      pair_step(12'd4095, 12'd1, 16'd0),
      pair_step(12'hAAA, 12'h555, 16'h5555),
      pair_step(12'h555, 12'hAAA, 16'hAAAA),
      pair_step(12'd4095, 12'd4094, 16'hFFFF)
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // The first requests also wait out the vertex table clearing after reset.
    drained = 1'b1;
    settings_used = 1;
    foreach (script[i]) begin
      if (script[i].kind == STEP_REG) begin
        if (!drained) wait_drained();
        write_reg(script[i].index, script[i].wdata);
        drained = 1'b1;
      end else begin
        push_edge(script[i].va, script[i].vb, script[i].coin, script[i].typed, script[i].want);
        drained = 1'b0;
      end
    end
    if (!drained) wait_drained();

    run_random_phase(300, 0, 0, 24, 1'b0);
    run_random_phase(300, 71, 0, 24, 1'b0);
    run_random_phase(300, 0, 71, 24, 1'b0);
    run_random_phase(300, 23, 23, 24, 1'b0);
    // Maximum weights on three vertices push the sums and then the estimate to saturation.
    run_random_phase(480, 0, 0, 3, 1'b1);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("requests left without a result", EST_W'(pending_results.size()), '0);

    $display("Run covered %0d edge requests under %0d register settings, %0d typed by hand.",
             edges_sent, settings_used, typed_rows);
    $display("Checked %0d results; final estimate %0h with %0d edges kept.",
             results_checked, est_acc, kept_tally);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
